FILE: sv/tbq_pkg.sv
package tbq_pkg;

	// axis fraction bits, Q2.30
	localparam int AXIS_FRAC = 30;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Z     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UP_X        = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Y        = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Z        = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NIGHT_MODE  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NIGHT_SCALE = 4'd7;

	localparam logic [15:0] NIGHT_SCALE_RST = 16'd256;

	// square root: one result bit per step, four steps per stage
	localparam int SQ_STEPS   = 31;
	localparam int SQ_PER_STG = 4;
	localparam int SQ_STAGES  = (SQ_STEPS + SQ_PER_STG - 1) / SQ_PER_STG;

	// division: one quotient bit per step, four steps per stage
	localparam int DV_STEPS   = 32;
	localparam int DV_PER_STG = 4;
	localparam int DV_STAGES  = DV_STEPS / DV_PER_STG;

	// leading one search over the side magnitude
	localparam int CHUNK_W = 8;
	localparam int N_CHUNK = 8;

	// vertex ingredients that ride along the pipeline
	typedef struct packed {
		logic [2:0][31:0] head;
		logic [2:0][31:0] tail;
		logic [2:0][32:0] ctr;
		logic [2:0][32:0] rr;
		logic [2:0][32:0] uu;
		logic [30:0]      w;
	} geo_t;

	typedef struct packed {
		geo_t             g;
		logic [2:0][30:0] sn;
		logic             zero;
		logic [61:0]      rad;
		logic [32:0]      rem;
		logic [30:0]      root;
	} sq_t;

	typedef struct packed {
		geo_t             g;
		logic             zero;
		logic [2:0]       neg;
		logic [30:0]      len;
		logic [2:0][31:0] rem;
		logic [2:0][31:0] num;
		logic [2:0][31:0] quo;
	} dv_t;

	// clamp to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'h7fffffff;
		end else if (v < -35'sd2147483648) begin
			return 32'h80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

FILE: sv/tracer_billboard_quads.sv
// An accepted word passes through the front stages, the square root, division and offset stages,
// then the serialiser strobes its eight vertices in one unbroken run.
// New segments enter while the single vertex result port serialises an earlier one;
// busy is raised while a finished segment waits for the vertex serialiser.
// Reset clears all valid bits and the serialiser, axes to 0, night scale to 1.0.
// Results cannot be stalled by the receiver.
module tracer_billboard_quads (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [31:0]            tail_x,
	input  logic signed [31:0]            tail_y,
	input  logic signed [31:0]            tail_z,
	input  logic signed [31:0]            head_x,
	input  logic signed [31:0]            head_y,
	input  logic signed [31:0]            head_z,
	input  logic [30:0]                   half_width,
	output logic                          vert_strobe,
	output logic signed [31:0]            vert_x,
	output logic signed [31:0]            vert_y,
	output logic signed [31:0]            vert_z,
	output logic                          tex_s,
	output logic                          tex_t,
	output logic                          quad_sel,
	output logic [1:0]                    corner,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tbq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import tbq_pkg::*;

	// configuration registers
	logic signed [31:0] right_q [3];
	logic signed [31:0] up_q [3];
	logic               night_mode_q;
	logic [15:0]        night_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				right_q[i] <= '0;
				up_q[i]    <= '0;
			end
			night_mode_q  <= 1'b0;
			night_scale_q <= NIGHT_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RIGHT_X:     right_q[0] <= cfg_data;
				REG_RIGHT_Y:     right_q[1] <= cfg_data;
				REG_RIGHT_Z:     right_q[2] <= cfg_data;
				REG_UP_X:        up_q[0] <= cfg_data;
				REG_UP_Y:        up_q[1] <= cfg_data;
				REG_UP_Z:        up_q[2] <= cfg_data;
				REG_NIGHT_MODE:  night_mode_q <= cfg_data[0];
				REG_NIGHT_SCALE: night_scale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline advance: whole pipe moves unless the last stage waits
	logic       adv;
	logic       ser_act_q;
	logic [2:0] ser_cnt_q;
	logic       ser_free;
	logic       ser_load;
	logic       v_s30;

	assign ser_free = !ser_act_q || (ser_cnt_q == 3'd7);
	assign adv      = !(v_s30 && !ser_free);
	assign busy     = !adv;
	assign ser_load = adv && v_s30;

	// valid bits of the front stages
	logic [13:1]          v_s;
	logic [SQ_STAGES-1:0] sq_v_s;
	logic [DV_STAGES-1:0] dv_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s    <= '0;
			sq_v_s <= '0;
			dv_v_s <= '0;
			v_s30  <= 1'b0;
		end else if (adv) begin
			v_s    <= {v_s[12:1], start};
			sq_v_s <= {sq_v_s[SQ_STAGES-2:0], v_s[13]};
			dv_v_s <= {dv_v_s[DV_STAGES-2:0], sq_v_s[SQ_STAGES-1]};
			v_s30  <= dv_v_s[DV_STAGES-1];
		end
	end

	// stage registers
	logic signed [31:0] tail_s1 [3];
	logic signed [31:0] head_s1 [3];
	logic [30:0]        hw_s1;

	logic signed [32:0] d_s2 [3];
	logic signed [31:0] tail_s2 [3];
	logic signed [31:0] head_s2 [3];
	logic [30:0]        w_s2;

	logic signed [34:0] pr_s3 [3];
	logic signed [34:0] pu_s3 [3];
	geo_t               geo_s3;

	logic signed [36:0] dr_s4;
	logic signed [36:0] du_s4;
	geo_t               geo_s4;

	logic signed [31:0] drn_s5;
	logic signed [31:0] dun_s5;
	geo_t               geo_s5;

	logic signed [63:0] ar_s6 [3];
	logic signed [63:0] bu_s6 [3];
	geo_t               geo_s6;

	logic signed [63:0] s_s7 [3];
	geo_t               geo_s7;

	logic [62:0]        m_s8;
	logic signed [63:0] s_s8 [3];
	geo_t               geo_s8;

	logic [N_CHUNK-1:0] nz_s9;
	logic [2:0]         pos_s9 [N_CHUNK];
	logic signed [63:0] s_s9 [3];
	geo_t               geo_s9;

	logic [6:0]         bl_s10;
	logic               zero_s10;
	logic signed [63:0] s_s10 [3];
	geo_t               geo_s10;

	logic signed [30:0] sn_s11 [3];
	logic               zero_s11;
	geo_t               geo_s11;

	logic [60:0]        sq_s12 [3];
	logic signed [30:0] sn_s12 [3];
	logic               zero_s12;
	geo_t               geo_s12;

	logic [61:0]        sum_s13;
	logic signed [30:0] sn_s13 [3];
	logic               zero_s13;
	geo_t               geo_s13;

	// combinational values of the front stages
	logic signed [32:0] d_c [3];
	logic [46:0]        wprod_c;
	logic [38:0]        wn_c;
	logic [30:0]        w_c;
	logic signed [64:0] pr_m [3];
	logic signed [64:0] pu_m [3];
	logic signed [63:0] rw_m [3];
	logic signed [63:0] uw_m [3];
	geo_t               geo_c3;
	logic [2:0]         dk_c;
	logic signed [36:0] drsh_c;
	logic signed [36:0] dush_c;
	logic signed [63:0] ar_m [3];
	logic signed [63:0] bu_m [3];
	logic [63:0]        mag_c [3];
	logic [62:0]        m_c;
	logic [63:0]        mpad_c;
	logic [N_CHUNK-1:0] nz_c;
	logic [2:0]         pos_c [N_CHUNK];
	logic [6:0]         bl_c;
	logic signed [63:0] sh_c [3];
	logic signed [61:0] sqm_c [3];

	// segment direction and night width
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = 33'(head_s1[i]) - 33'(tail_s1[i]);
		end
		wprod_c = 47'(hw_s1) * 47'(night_scale_q);
		wn_c    = wprod_c[46:8];
		if (!night_mode_q) begin
			w_c = hw_s1;
		end else if (wn_c > 39'd2147483647) begin
			w_c = 31'h7fffffff;
		end else begin
			w_c = wn_c[30:0];
		end
	end

	// axis products against direction and width, centre point
	always_comb begin
		geo_c3   = '0;
		geo_c3.w = w_s2;
		for (int i = 0; i < 3; i++) begin
			pr_m[i] = right_q[i] * d_s2[i];
			pu_m[i] = up_q[i] * d_s2[i];
			rw_m[i] = right_q[i] * $signed({1'b0, w_s2});
			uw_m[i] = up_q[i] * $signed({1'b0, w_s2});
			geo_c3.head[i] = head_s2[i];
			geo_c3.tail[i] = tail_s2[i];
			geo_c3.ctr[i]  = 33'(tail_s2[i]) + 33'($signed(d_s2[i][32:1]));
			geo_c3.rr[i]   = rw_m[i][62:30];
			geo_c3.uu[i]   = uw_m[i][62:30];
		end
	end

	// bring both dot products into the signed 32-bit range with a common shift
	always_comb begin
		dk_c = 3'd6;
		for (int k = 6; k >= 0; k--) begin
			if (((dr_s4 >>> k) <= 37'sd2147483647) && ((dr_s4 >>> k) >= -37'sd2147483647) &&
			    ((du_s4 >>> k) <= 37'sd2147483647) && ((du_s4 >>> k) >= -37'sd2147483647)) begin
				dk_c = 3'(k);
			end
		end
		drsh_c = dr_s4 >>> dk_c;
		dush_c = du_s4 >>> dk_c;
	end

	// side products, magnitude, leading one search
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ar_m[i]  = right_q[i] * dun_s5;
			bu_m[i]  = up_q[i] * drn_s5;
			mag_c[i] = s_s7[i][63] ? 64'(-s_s7[i]) : 64'(s_s7[i]);
		end
		m_c = mag_c[0][62:0];
		if (mag_c[1][62:0] > m_c) m_c = mag_c[1][62:0];
		if (mag_c[2][62:0] > m_c) m_c = mag_c[2][62:0];

		mpad_c = {1'b0, m_s8};
		for (int ch = 0; ch < N_CHUNK; ch++) begin
			nz_c[ch]  = |mpad_c[ch*CHUNK_W +: CHUNK_W];
			pos_c[ch] = 3'd0;
			for (int b = 0; b < CHUNK_W; b++) begin
				if (mpad_c[ch*CHUNK_W + b]) pos_c[ch] = 3'(b);
			end
		end

		bl_c = 7'd0;
		for (int ch = 0; ch < N_CHUNK; ch++) begin
			if (nz_s9[ch]) bl_c = 7'(ch * CHUNK_W) + 7'(pos_s9[ch]) + 7'd1;
		end
	end

	// normalising shift and squares
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (bl_s10 > 7'd30) begin
				sh_c[i] = s_s10[i] >>> (bl_s10 - 7'd30);
			end else begin
				sh_c[i] = s_s10[i] <<< (7'd30 - bl_s10);
			end
			sqm_c[i] = sn_s11[i] * sn_s11[i];
		end
	end

	// front stage registers
	always_ff @(posedge clk) begin
		if (adv) begin
			tail_s1[0] <= tail_x;
			tail_s1[1] <= tail_y;
			tail_s1[2] <= tail_z;
			head_s1[0] <= head_x;
			head_s1[1] <= head_y;
			head_s1[2] <= head_z;
			hw_s1      <= half_width;

			d_s2    <= d_c;
			tail_s2 <= tail_s1;
			head_s2 <= head_s1;
			w_s2    <= w_c;

			for (int i = 0; i < 3; i++) begin
				pr_s3[i] <= pr_m[i][64:30];
				pu_s3[i] <= pu_m[i][64:30];
			end
			geo_s3 <= geo_c3;

			dr_s4  <= 37'(pr_s3[0]) + 37'(pr_s3[1]) + 37'(pr_s3[2]);
			du_s4  <= 37'(pu_s3[0]) + 37'(pu_s3[1]) + 37'(pu_s3[2]);
			geo_s4 <= geo_s3;

			drn_s5 <= drsh_c[31:0];
			dun_s5 <= dush_c[31:0];
			geo_s5 <= geo_s4;

			ar_s6  <= ar_m;
			bu_s6  <= bu_m;
			geo_s6 <= geo_s5;

			for (int i = 0; i < 3; i++) begin
				s_s7[i] <= ar_s6[i] - bu_s6[i];
			end
			geo_s7 <= geo_s6;

			m_s8   <= m_c;
			s_s8   <= s_s7;
			geo_s8 <= geo_s7;

			nz_s9  <= nz_c;
			pos_s9 <= pos_c;
			s_s9   <= s_s8;
			geo_s9 <= geo_s8;

			bl_s10   <= bl_c;
			zero_s10 <= !(|nz_s9);
			s_s10    <= s_s9;
			geo_s10  <= geo_s9;

			for (int i = 0; i < 3; i++) begin
				sn_s11[i] <= sh_c[i][30:0];
			end
			zero_s11 <= zero_s10;
			geo_s11  <= geo_s10;

			for (int i = 0; i < 3; i++) begin
				sq_s12[i] <= sqm_c[i][60:0];
			end
			sn_s12   <= sn_s11;
			zero_s12 <= zero_s11;
			geo_s12  <= geo_s11;

			sum_s13  <= 62'(sq_s12[0]) + 62'(sq_s12[1]) + 62'(sq_s12[2]);
			sn_s13   <= sn_s12;
			zero_s13 <= zero_s12;
			geo_s13  <= geo_s12;
		end
	end

	// integer square root, stages 14 to 21
	sq_t sq_s [SQ_STAGES];
	sq_t sq_init;

	always_comb begin
		sq_init      = '0;
		sq_init.g    = geo_s13;
		sq_init.zero = zero_s13;
		sq_init.rad  = sum_s13;
		for (int i = 0; i < 3; i++) begin
			sq_init.sn[i] = sn_s13[i];
		end
	end

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		sq_t cur;
		sq_t nxt;

		if (k == 0) begin : g_first
			assign cur = sq_init;
		end else begin : g_next
			assign cur = sq_s[k-1];
		end

		always_comb begin
			logic [34:0] t;
			logic [34:0] tr;
			t   = '0;
			tr  = '0;
			nxt = cur;
			for (int j = 0; j < SQ_PER_STG; j++) begin
				if (k * SQ_PER_STG + j < SQ_STEPS) begin
					t  = {nxt.rem, nxt.rad[61:60]};
					tr = {2'b00, nxt.root, 2'b01};
					if (t >= tr) begin
						nxt.rem  = 33'(t - tr);
						nxt.root = {nxt.root[29:0], 1'b1};
					end else begin
						nxt.rem  = t[32:0];
						nxt.root = {nxt.root[29:0], 1'b0};
					end
					nxt.rad = {nxt.rad[59:0], 2'b00};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) sq_s[k] <= nxt;
		end
	end

	// unit side components by division, stages 22 to 29
	dv_t dv_s [DV_STAGES];
	dv_t dv_init;

	always_comb begin
		logic [30:0] a;
		a            = '0;
		dv_init      = '0;
		dv_init.g    = sq_s[SQ_STAGES-1].g;
		dv_init.zero = sq_s[SQ_STAGES-1].zero;
		dv_init.len  = sq_s[SQ_STAGES-1].root;
		for (int i = 0; i < 3; i++) begin
			dv_init.neg[i] = sq_s[SQ_STAGES-1].sn[i][30];
			a = dv_init.neg[i] ? 31'(-sq_s[SQ_STAGES-1].sn[i]) : sq_s[SQ_STAGES-1].sn[i];
			dv_init.rem[i] = {3'b000, a[30:2]};
			dv_init.num[i] = {a[1:0], 30'd0};
		end
	end

	for (genvar k = 0; k < DV_STAGES; k++) begin : g_div
		dv_t cur;
		dv_t nxt;

		if (k == 0) begin : g_first
			assign cur = dv_init;
		end else begin : g_next
			assign cur = dv_s[k-1];
		end

		always_comb begin
			logic [31:0] t;
			t   = '0;
			nxt = cur;
			for (int j = 0; j < DV_PER_STG; j++) begin
				for (int i = 0; i < 3; i++) begin
					t = {nxt.rem[i][30:0], nxt.num[i][31]};
					if (t >= {1'b0, nxt.len}) begin
						nxt.rem[i] = t - {1'b0, nxt.len};
						nxt.quo[i] = {nxt.quo[i][30:0], 1'b1};
					end else begin
						nxt.rem[i] = t;
						nxt.quo[i] = {nxt.quo[i][30:0], 1'b0};
					end
					nxt.num[i] = {nxt.num[i][30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) dv_s[k] <= nxt;
		end
	end

	// ribbon offset: unit side times width, stage 30
	geo_t               geo_s30;
	logic [2:0][32:0]   off_s30;
	logic signed [31:0] n_c [3];
	logic signed [63:0] off_m [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_s[DV_STAGES-1].zero) begin
				n_c[i] = '0;
			end else if (dv_s[DV_STAGES-1].neg[i]) begin
				n_c[i] = -$signed(dv_s[DV_STAGES-1].quo[i]);
			end else begin
				n_c[i] = $signed(dv_s[DV_STAGES-1].quo[i]);
			end
			off_m[i] = n_c[i] * $signed({1'b0, dv_s[DV_STAGES-1].g.w});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s30 <= dv_s[DV_STAGES-1].g;
			for (int i = 0; i < 3; i++) begin
				off_s30[i] <= off_m[i][62:30];
			end
		end
	end

	// vertex serialiser: eight words per segment
	geo_t             ser_g_q;
	logic [2:0][32:0] ser_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_act_q <= 1'b0;
			ser_cnt_q <= '0;
		end else if (ser_load) begin
			ser_act_q <= 1'b1;
			ser_cnt_q <= '0;
		end else if (ser_act_q) begin
			if (ser_cnt_q == 3'd7) ser_act_q <= 1'b0;
			ser_cnt_q <= ser_cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			ser_g_q   <= geo_s30;
			ser_off_q <= off_s30;
		end
	end

	// vertex arithmetic for the current corner
	logic [1:0]         cn_c;
	logic               plus_c;
	logic               upper_c;
	logic signed [34:0] base_c;
	logic signed [34:0] vtx_c [3];
	logic [31:0]        vsat_c [3];

	always_comb begin
		cn_c    = ser_cnt_q[1:0];
		plus_c  = (cn_c == 2'd0) || (cn_c == 2'd3);
		upper_c = !cn_c[1];
		base_c  = '0;
		for (int i = 0; i < 3; i++) begin
			if (!ser_cnt_q[2]) begin
				base_c  = upper_c ? 35'($signed(ser_g_q.head[i])) :
				                    35'($signed(ser_g_q.tail[i]));
				vtx_c[i] = plus_c ? base_c + 35'($signed(ser_off_q[i])) :
				                    base_c - 35'($signed(ser_off_q[i]));
			end else begin
				vtx_c[i] = 35'($signed(ser_g_q.ctr[i]))
				         + (plus_c ? 35'($signed(ser_g_q.rr[i])) :
				                     -35'($signed(ser_g_q.rr[i])))
				         + (upper_c ? 35'($signed(ser_g_q.uu[i])) :
				                      -35'($signed(ser_g_q.uu[i])));
			end
			vsat_c[i] = sat32(vtx_c[i]);
		end
	end

	// output registers
	logic        strobe_q;
	logic [31:0] vx_q;
	logic [31:0] vy_q;
	logic [31:0] vz_q;
	logic        ts_q;
	logic        tt_q;
	logic        qs_q;
	logic [1:0]  cn_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ser_act_q;
		end
	end

	always_ff @(posedge clk) begin
		vx_q   <= vsat_c[0];
		vy_q   <= vsat_c[1];
		vz_q   <= vsat_c[2];
		ts_q   <= upper_c;
		tt_q   <= plus_c;
		qs_q   <= ser_cnt_q[2];
		cn_q   <= cn_c;
		last_q <= (ser_cnt_q == 3'd7);
	end

	assign vert_strobe = strobe_q;
	assign vert_x      = vx_q;
	assign vert_y      = vy_q;
	assign vert_z      = vz_q;
	assign tex_s       = ts_q;
	assign tex_t       = tt_q;
	assign quad_sel    = qs_q;
	assign corner      = cn_q;
	assign last        = last_q;

	// the eight words of a segment come in one unbroken run
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		vert_strobe && !last |=> vert_strobe)
		else $error("vertex run broken");

	// corners step through both quads in order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		vert_strobe && !last |=> {quad_sel, corner} == $past({quad_sel, corner}) + 3'd1)
		else $error("vertex order wrong");

	// busy only while a finished segment waits on the serialiser
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> v_s30 && ser_act_q && (ser_cnt_q != 3'd7))
		else $error("busy without a waiting segment");

endmodule
